// File: design/skc_pkg.sv
// Package with the shared types, constants and constant functions of the stereo compressor.
`timescale 1ns / 1ps
`default_nettype none
package skc_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX       = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMITER   = 4'd7;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 66;

	localparam int DIV_NUM_W = 27;
	localparam int KNEE_W    = 13;

	localparam logic signed [15:0] DB_FLOOR   = -16'sd25600;
	localparam logic [32:0]        LOG_SCALE  = 33'd394566;
	localparam logic [32:0]        GAIN_SCALE = 33'd10885;

	typedef enum logic [4:0] {
		S_IDLE, S_NORM, S_SQR, S_LVL, S_CURVE, S_KSQ, S_KMUL, S_KDIV,
		S_SM1, S_SM2, S_P, S_G, S_WG, S_WET, S_DRY, S_MH, S_ML, S_DONE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [KNEE_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

	// Rounds to nearest with ties away from zero.
	function automatic logic signed [PROD_W-1:0] rnd_shift(logic signed [PROD_W-1:0] v,
			int unsigned sh);
		logic [PROD_W-1:0] mag;
		begin
			mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
			mag = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
			return v[PROD_W-1] ? -$signed(mag) : $signed(mag);
		end
	endfunction

	// Limits a reduction to the range -32768..0.
	function automatic logic signed [15:0] clamp_red(logic signed [PROD_W-1:0] v);
		begin
			if (v > 0)
				return 16'sd0;
			else if (v < -66'sd32768)
				return -16'sd32768;
			else
				return v[15:0];
		end
	endfunction

	function automatic logic [63:0] isqrt64(logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		begin
			n = n_in;
			r = 64'd0;
			b = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		end
	endfunction

	// 2^(-2^-k) in Q1.30, by repeated square roots starting from one half.
	function automatic logic [30:0] gain_root(int k);
		logic [63:0] s;
		begin
			s = 64'd1 << 29;
			for (int i = 0; i < k; i++)
				s = isqrt64(s << 30);
			return s[30:0];
		end
	endfunction

endpackage
`default_nettype wire

// File: design/skc_if.sv
// Handshake channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface skc_sample_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;
	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface skc_result_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic signed [15:0]            reduction_db;
	modport source (output valid, output left_out, output right_out, output reduction_db,
		input ready);
	modport sink (input valid, input left_out, input right_out, input reduction_db,
		output ready);
endinterface

interface skc_cfg_if ();
	logic                             valid;
	logic                             ready;
	logic [skc_pkg::CFG_IDX_W-1:0]    index;
	logic [skc_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: design/soft_knee_stereo_compressor.sv
// Top level of the stereo soft knee compressor with its sequencer and shared multiplier.
//
// Channel  Dir  Beat
// sample   in   left_in, right_in (one stereo pair)
// result   out  left_out, right_out, reduction_db
// cfg      in   index, data (one register write, always ready)
//
// A zero pair is shortest, as it skips the level measurement; the leading-one
// search and the soft knee, most of it spent in the divide, make a pair longer.
// Every product goes through the single 33x33 multiplier, one per cycle.
// A finished result waits in the output register; the next pair is taken meanwhile,
// and its result holds the sequencer in the last state until the register is free.
// Reset restores the register defaults and sets the smoothed reduction to 0 dB.
`timescale 1ns / 1ps
`default_nettype none
module soft_knee_stereo_compressor #(
	parameter int SAMPLE_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	skc_sample_if.sink   sample,
	skc_result_if.source result,
	skc_cfg_if.sink      cfg
);
	localparam int     SB  = SAMPLE_BITS;
	localparam longint FS  = longint'(1) << (SAMPLE_BITS - 1);
	localparam longint LIM = (FS * 98 + 50) / 100;
	localparam logic signed [65:0] FS_MAX = 66'(FS - 1);
	localparam logic signed [65:0] FS_MIN = 66'(-FS);
	localparam logic signed [65:0] LIM_P  = 66'(LIM);
	localparam logic signed [65:0] LIM_N  = 66'(-LIM);
	localparam logic signed [22:0] REL_OFS = 23'((SAMPLE_BITS - 1) * 65536);

	skc_pkg::state_t state_q, state_d;

	logic signed [15:0] thr_q;
	logic signed [16:0] slope_q;
	logic [12:0]        knee_q;
	logic [15:0]        att_q;
	logic [15:0]        rls_q;
	logic [23:0]        wet_gain_q;
	logic [16:0]        mix_q;
	logic               lim_on_q;

	logic signed [SB-1:0] xl_q, xr_q;
	logic [31:0]          nrm_q;
	logic [4:0]           exp_q;
	logic [30:0]          m_q;
	logic [15:0]          frac_q;
	logic [3:0]           cnt_q;
	logic signed [15:0]   lvl_q;
	logic [14:0]          x2_q;
	logic [27:0]          sq2_q;
	logic                 neg_q;
	logic signed [15:0]   target_q;
	logic signed [15:0]   red_q;
	logic signed [65:0]   acc_q;
	logic [20:0]          p_q;
	logic [30:0]          g_q;
	logic [24:0]          wg_q;
	logic signed [41:0]   wet_q;
	logic                 ch_q;
	logic signed [SB-1:0] outl_q, outr_q;
	logic signed [SB-1:0] res_l_q, res_r_q;
	logic signed [15:0]   res_red_q;
	logic                 res_valid_q;

	logic [30:0] gs_tab [16];

	for (genvar gi = 0; gi < 16; gi++) begin : g_roots
		localparam logic [30:0] ROOT = skc_pkg::gain_root(gi + 1);
		assign gs_tab[gi] = ROOT;
	end

	// Configuration port.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= -16'sd4608;
			slope_q    <= -17'sd49152;
			knee_q     <= 13'd1536;
			att_q      <= 16'd65399;
			rls_q      <= 16'd65522;
			wet_gain_q <= 24'd142680;
			mix_q      <= 17'd65536;
			lim_on_q   <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				skc_pkg::CFG_THRESHOLD: thr_q      <= cfg.data[15:0];
				skc_pkg::CFG_SLOPE:     slope_q    <= cfg.data[16:0];
				skc_pkg::CFG_KNEE:      knee_q     <= cfg.data[12:0];
				skc_pkg::CFG_ATTACK:    att_q      <= cfg.data[15:0];
				skc_pkg::CFG_RELEASE:   rls_q      <= cfg.data[15:0];
				skc_pkg::CFG_WET_GAIN:  wet_gain_q <= cfg.data[23:0];
				skc_pkg::CFG_MIX:       mix_q      <= cfg.data[16:0];
				skc_pkg::CFG_LIMITER:   lim_on_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Input magnitudes and linked peak.
	logic [SB-1:0] abs_l, abs_r, peak;
	assign abs_l = sample.left_in[SB-1] ? SB'(-sample.left_in) : SB'(sample.left_in);
	assign abs_r = sample.right_in[SB-1] ? SB'(-sample.right_in) : SB'(sample.right_in);
	assign peak  = (abs_l > abs_r) ? abs_l : abs_r;

	// Derived operands.
	logic signed [22:0] rel;
	logic signed [17:0] ovr;
	logic signed [18:0] two_o, kx;
	logic               is_zero, is_hard;
	logic [15:0]        coef;
	logic [16:0]        coef_c;
	logic [16:0]        neg_red;
	logic [16:0]        m_eff, m_comp;
	logic [4:0]         ip;
	logic [15:0]        p_frac;
	logic [30:0]        gain;
	logic signed [SB-1:0] x_cur;

	assign rel     = $signed({2'b00, exp_q, frac_q}) - REL_OFS;
	assign ovr     = {{2{lvl_q[15]}}, lvl_q} - {{2{thr_q[15]}}, thr_q};
	assign two_o   = {ovr, 1'b0};
	assign kx      = $signed({6'b0, knee_q});
	assign is_zero = two_o <= -kx;
	assign is_hard = (two_o >= kx) || (knee_q == 13'd0);
	assign coef    = (target_q < red_q) ? att_q : rls_q;
	assign coef_c  = 17'd65536 - {1'b0, coef};
	assign neg_red = 17'd0 - {red_q[15], red_q};
	assign m_eff   = (mix_q > 17'd65536) ? 17'd65536 : mix_q;
	assign m_comp  = 17'd65536 - m_eff;
	assign ip      = p_q[20:16];
	assign p_frac  = p_q[15:0];
	assign gain    = (ip >= 5'd31) ? 31'd0 : (g_q >> ip);
	assign x_cur   = ch_q ? xr_q : xl_q;

	// Shared multiplier.
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			skc_pkg::S_SQR: begin
				mul_a = {2'b00, m_q};
				mul_b = {2'b00, m_q};
			end
			skc_pkg::S_LVL: begin
				mul_a = {{10{rel[22]}}, rel};
				mul_b = skc_pkg::LOG_SCALE;
			end
			skc_pkg::S_CURVE: begin
				mul_a = {{15{ovr[17]}}, ovr};
				mul_b = {{16{slope_q[16]}}, slope_q};
			end
			skc_pkg::S_KSQ: begin
				mul_a = {18'b0, x2_q};
				mul_b = {18'b0, x2_q};
			end
			skc_pkg::S_KMUL: begin
				mul_a = {{16{slope_q[16]}}, slope_q};
				mul_b = {5'b0, sq2_q};
			end
			skc_pkg::S_SM1: begin
				mul_a = {17'b0, coef};
				mul_b = {{17{red_q[15]}}, red_q};
			end
			skc_pkg::S_SM2: begin
				mul_a = {16'b0, coef_c};
				mul_b = {{17{target_q[15]}}, target_q};
			end
			skc_pkg::S_P: begin
				mul_a = {16'b0, neg_red};
				mul_b = skc_pkg::GAIN_SCALE;
			end
			skc_pkg::S_G: begin
				mul_a = {2'b00, g_q};
				mul_b = {2'b00, gs_tab[cnt_q]};
			end
			skc_pkg::S_WG: begin
				mul_a = {9'b0, wet_gain_q};
				mul_b = {2'b00, gain};
			end
			skc_pkg::S_WET: begin
				mul_a = {{(33 - SB){x_cur[SB-1]}}, x_cur};
				mul_b = {8'b0, wg_q};
			end
			skc_pkg::S_DRY: begin
				mul_a = {{(33 - SB){x_cur[SB-1]}}, x_cur};
				mul_b = {16'b0, m_comp};
			end
			skc_pkg::S_MH: begin
				mul_a = {{7{wet_q[41]}}, wet_q[41:16]};
				mul_b = {16'b0, m_eff};
			end
			skc_pkg::S_ML: begin
				mul_a = {17'b0, wet_q[15:0]};
				mul_b = {16'b0, m_eff};
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// Per-step results taken from the product.
	logic [31:0]        sq;
	logic signed [65:0] db;
	logic signed [65:0] hard_gr;
	logic [65:0]        kmag;
	logic [65:0]        knum;
	logic signed [65:0] sm_sum;
	logic signed [65:0] p_tmp;
	logic signed [65:0] g_tmp;
	logic signed [65:0] wg_tmp;
	logic signed [65:0] wet_val;
	logic signed [65:0] mix_sum;
	logic signed [65:0] mix_rnd;
	logic signed [65:0] lim_val;
	logic signed [65:0] sat_val;
	logic signed [65:0] soft_gr;

	assign sq      = prod[61:30];
	assign db      = skc_pkg::rnd_shift(prod, 24);
	assign hard_gr = skc_pkg::rnd_shift(prod, 16);
	assign kmag    = prod[65] ? 66'(-prod) : 66'(prod);
	assign knum    = kmag + ({53'b0, knee_q} << 18);
	assign sm_sum  = skc_pkg::rnd_shift(acc_q + prod, 16);
	assign p_tmp   = prod + 66'sd128;
	assign g_tmp   = prod + (66'sd1 <<< 29);
	assign wg_tmp  = prod + (66'sd1 <<< 29);
	assign wet_val = skc_pkg::rnd_shift(prod, 16);
	assign mix_sum = acc_q + prod;
	assign mix_rnd = skc_pkg::rnd_shift(mix_sum, 16);

	always_comb begin
		lim_val = mix_rnd;
		if (lim_on_q) begin
			if (lim_val > LIM_P)
				lim_val = LIM_P;
			if (lim_val < LIM_N)
				lim_val = LIM_N;
		end
		sat_val = lim_val;
		if (sat_val > FS_MAX)
			sat_val = FS_MAX;
		if (sat_val < FS_MIN)
			sat_val = FS_MIN;
	end

	// Soft knee divide.
	skc_pkg::div_req_t div_req;
	skc_pkg::div_rsp_t div_rsp;

	assign div_req.start    = (state_q == skc_pkg::S_KMUL);
	assign div_req.dividend = knum[45:19];
	assign div_req.divisor  = knee_q;

	skc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign soft_gr = neg_q ? -$signed({39'b0, div_rsp.quotient})
		: $signed({39'b0, div_rsp.quotient});

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= skc_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			skc_pkg::S_IDLE:
				if (sample.valid)
					state_d = (peak == '0) ? skc_pkg::S_CURVE : skc_pkg::S_NORM;
			skc_pkg::S_NORM:
				if (nrm_q[31])
					state_d = skc_pkg::S_SQR;
			skc_pkg::S_SQR:
				if (cnt_q == 4'd15)
					state_d = skc_pkg::S_LVL;
			skc_pkg::S_LVL:   state_d = skc_pkg::S_CURVE;
			skc_pkg::S_CURVE:
				state_d = (is_zero || is_hard) ? skc_pkg::S_SM1 : skc_pkg::S_KSQ;
			skc_pkg::S_KSQ:   state_d = skc_pkg::S_KMUL;
			skc_pkg::S_KMUL:  state_d = skc_pkg::S_KDIV;
			skc_pkg::S_KDIV:
				if (div_rsp.done)
					state_d = skc_pkg::S_SM1;
			skc_pkg::S_SM1:   state_d = skc_pkg::S_SM2;
			skc_pkg::S_SM2:   state_d = skc_pkg::S_P;
			skc_pkg::S_P:     state_d = skc_pkg::S_G;
			skc_pkg::S_G:
				if (cnt_q == 4'd15)
					state_d = skc_pkg::S_WG;
			skc_pkg::S_WG:    state_d = skc_pkg::S_WET;
			skc_pkg::S_WET:   state_d = skc_pkg::S_DRY;
			skc_pkg::S_DRY:   state_d = skc_pkg::S_MH;
			skc_pkg::S_MH:    state_d = skc_pkg::S_ML;
			skc_pkg::S_ML:
				state_d = ch_q ? skc_pkg::S_DONE : skc_pkg::S_WET;
			skc_pkg::S_DONE:
				if (!res_valid_q || result.ready)
					state_d = skc_pkg::S_IDLE;
			default: state_d = skc_pkg::S_IDLE;
		endcase
	end

	assign sample.ready = (state_q == skc_pkg::S_IDLE);

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			skc_pkg::S_IDLE:
				if (sample.valid) begin
					xl_q  <= sample.left_in;
					xr_q  <= sample.right_in;
					nrm_q <= 32'(peak);
					exp_q <= 5'd31;
					lvl_q <= skc_pkg::DB_FLOOR;
				end
			skc_pkg::S_NORM:
				if (nrm_q[31]) begin
					m_q    <= nrm_q[31:1];
					frac_q <= '0;
					cnt_q  <= '0;
				end else begin
					nrm_q <= nrm_q << 1;
					exp_q <= exp_q - 1'b1;
				end
			skc_pkg::S_SQR: begin
				// A square at or above two sets the next fraction bit.
				if (sq[31]) begin
					m_q    <= sq[31:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= sq[30:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			skc_pkg::S_LVL:
				lvl_q <= (db < 66'(skc_pkg::DB_FLOOR)) ? skc_pkg::DB_FLOOR : db[15:0];
			skc_pkg::S_CURVE: begin
				if (is_zero)
					target_q <= '0;
				else if (is_hard)
					target_q <= skc_pkg::clamp_red(hard_gr);
				x2_q <= 15'(two_o + kx);
			end
			skc_pkg::S_KSQ:
				sq2_q <= prod[27:0];
			skc_pkg::S_KMUL:
				neg_q <= prod[65];
			skc_pkg::S_KDIV:
				if (div_rsp.done)
					target_q <= skc_pkg::clamp_red(soft_gr);
			skc_pkg::S_SM1:
				acc_q <= prod;
			skc_pkg::S_P: begin
				p_q   <= p_tmp[28:8];
				g_q   <= 31'd1 << 30;
				cnt_q <= '0;
			end
			skc_pkg::S_G: begin
				if (p_frac[4'd15 - cnt_q])
					g_q <= g_tmp[60:30];
				cnt_q <= cnt_q + 1'b1;
			end
			skc_pkg::S_WG: begin
				wg_q <= wg_tmp[54:30];
				ch_q <= 1'b0;
			end
			skc_pkg::S_WET:
				wet_q <= wet_val[41:0];
			skc_pkg::S_DRY:
				acc_q <= prod;
			skc_pkg::S_MH:
				acc_q <= acc_q + (prod <<< 16);
			skc_pkg::S_ML: begin
				if (ch_q)
					outr_q <= sat_val[SB-1:0];
				else
					outl_q <= sat_val[SB-1:0];
				ch_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// Smoothed reduction is the only state carried between pairs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			red_q <= '0;
		else if (state_q == skc_pkg::S_SM2)
			red_q <= skc_pkg::clamp_red(sm_sum);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == skc_pkg::S_DONE && (!res_valid_q || result.ready)) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == skc_pkg::S_DONE && (!res_valid_q || result.ready)) begin
			res_l_q   <= outl_q;
			res_r_q   <= outr_q;
			res_red_q <= red_q;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.left_out     = res_l_q;
	assign result.right_out    = res_r_q;
	assign result.reduction_db = res_red_q;
endmodule
`default_nettype wire

// File: design/skc_div.sv
// Restoring divider, one quotient bit per cycle, used for the soft knee scaling.
`timescale 1ns / 1ps
`default_nettype none
module skc_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire skc_pkg::div_req_t req,
	output skc_pkg::div_rsp_t    rsp
);
	localparam int NUM_W = skc_pkg::DIV_NUM_W;
	localparam int DEN_W = skc_pkg::KNEE_W;
	localparam int CNT_W = $clog2(NUM_W);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             take;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench of the stereo soft knee compressor with a bit-exact predictor.
`timescale 1ns / 1ps
`default_nettype none

class comp_scoreboard;
	logic signed [23:0] exp_left[$];
	logic signed [23:0] exp_right[$];
	logic signed [15:0] exp_red[$];
	int errors;
	int checked;

	function new();
		errors = 0;
		checked = 0;
	endfunction

	function void note(logic signed [23:0] l, logic signed [23:0] r, logic signed [15:0] red);
		exp_left.insert(exp_left.size(), l);
		exp_right.insert(exp_right.size(), r);
		exp_red.insert(exp_red.size(), red);
	endfunction

	function void check(logic signed [23:0] l, logic signed [23:0] r, logic signed [15:0] red);
		logic signed [23:0] el;
		logic signed [23:0] er;
		logic signed [15:0] ed;
		if (exp_left.size() == 0) begin
			$display("%0t: unexpected result L=%0d R=%0d red=%0d", $time, l, r, red);
			errors++;
			return;
		end
		el = exp_left.pop_front();
		er = exp_right.pop_front();
		ed = exp_red.pop_front();
		checked++;
		if (l !== el) begin
			$display("%0t: left_out expected %0d actual %0d", $time, el, l);
			errors++;
		end
		if (r !== er) begin
			$display("%0t: right_out expected %0d actual %0d", $time, er, r);
			errors++;
		end
		if (red !== ed) begin
			$display("%0t: reduction_db expected %0d actual %0d", $time, ed, red);
			errors++;
		end
	endfunction

	function int pending();
		return exp_left.size();
	endfunction
endclass

module tb;
	logic clk;
	logic arst_n;

	skc_sample_if #(.SAMPLE_BITS(24)) sample ();
	skc_result_if #(.SAMPLE_BITS(24)) result ();
	skc_cfg_if cfg ();

	soft_knee_stereo_compressor #(.SAMPLE_BITS(24)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg(cfg)
	);

	// Predictor copy of the registers and the smoothing state.
	longint thr_db;
	longint slope;
	longint knee;
	longint atk;
	longint rel;
	longint wgain;
	longint mix;
	bit lim_on;
	longint smooth_red;

	comp_scoreboard sb;
	int n_pairs;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_shift(longint v, int sh);
		longint half;
		half = longint'(1) << (sh - 1);
		if (v >= 0)
			return (v + half) >>> sh;
		return -((-v + half) >>> sh);
	endfunction

	function automatic longint round_div(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint peak_to_db(longint unsigned a);
		int msb;
		longint unsigned m;
		longint unsigned frac;
		longint lvl_rel;
		longint db;
		if (a == 0)
			return -25600;
		msb = 0;
		while ((a >> (msb + 1)) != 0)
			msb++;
		m = (msb >= 30) ? (a >> (msb - 30)) : (a << (30 - msb));
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				frac |= 1;
			end
		end
		lvl_rel = longint'((longint'(msb) << 16) | frac) - 23 * 65536;
		db = round_shift(lvl_rel * 394566, 24);
		return (db < -25600) ? -25600 : db;
	endfunction

	function automatic longint target_reduction(longint lvl);
		longint o;
		longint gr;
		longint x2;
		o = lvl - thr_db;
		if (2 * o <= -knee)
			return 0;
		if (2 * o >= knee || knee == 0) begin
			gr = round_shift(o * slope, 16);
		end else begin
			x2 = 2 * o + knee;
			gr = round_div(slope * x2 * x2, 65536 * 8 * knee);
		end
		if (gr > 0)
			gr = 0;
		if (gr < -32768)
			gr = -32768;
		return gr;
	endfunction

	function automatic longint unsigned red_to_gain(longint r);
		longint p;
		longint unsigned ip;
		longint unsigned fr;
		longint unsigned g;
		longint unsigned s;
		p = round_shift(-r * 10885, 8);
		ip = longint'(p) >> 16;
		fr = p & 16'hFFFF;
		g = 64'd1 << 30;
		s = 64'd1 << 29;
		for (int k = 1; k <= 16; k++) begin
			s = int_sqrt(s << 30);
			if ((fr >> (16 - k)) & 1)
				g = (g * s + (64'd1 << 29)) >> 30;
		end
		if (ip >= 31)
			return 0;
		return g >> ip;
	endfunction

	function automatic logic signed [23:0] mix_channel(longint x, longint wg, longint m);
		longint lim;
		longint wet;
		longint o;
		lim = ((longint'(1) << 23) * 98 + 50) / 100;
		wet = round_shift(x * wg, 16);
		o = round_shift(x * (65536 - m) + wet * m, 16);
		if (lim_on) begin
			if (o > lim) o = lim;
			if (o < -lim) o = -lim;
		end
		if (o > 8388607) o = 8388607;
		if (o < -8388608) o = -8388608;
		return o[23:0];
	endfunction

	function automatic void predict_pair(logic signed [23:0] l_in, logic signed [23:0] r_in);
		longint l;
		longint r;
		longint unsigned peak;
		longint tgt;
		longint c;
		longint m;
		longint unsigned wg;
		l = l_in;
		r = r_in;
		peak = (l < 0 ? -l : l) > (r < 0 ? -r : r) ? (l < 0 ? -l : l) : (r < 0 ? -r : r);
		tgt = target_reduction(peak_to_db(peak));
		c = (tgt < smooth_red) ? atk : rel;
		m = (mix > 65536) ? 65536 : mix;
		smooth_red = round_shift(c * smooth_red + (65536 - c) * tgt, 16);
		if (smooth_red > 0) smooth_red = 0;
		if (smooth_red < -32768) smooth_red = -32768;
		wg = (longint'(wgain) * red_to_gain(smooth_red) + (64'd1 << 29)) >> 30;
		sb.note(mix_channel(l, wg, m), mix_channel(r, wg, m), smooth_red[15:0]);
	endfunction

	task automatic write_reg(logic [skc_pkg::CFG_IDX_W-1:0] idx, longint value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value[skc_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			skc_pkg::CFG_THRESHOLD: thr_db = longint'($signed(value[15:0]));
			skc_pkg::CFG_SLOPE: slope = longint'($signed(value[16:0]));
			skc_pkg::CFG_KNEE: knee = value & 13'h1FFF;
			skc_pkg::CFG_ATTACK: atk = value & 16'hFFFF;
			skc_pkg::CFG_RELEASE: rel = value & 16'hFFFF;
			skc_pkg::CFG_WET_GAIN: wgain = value & 24'hFFFFFF;
			skc_pkg::CFG_MIX: mix = value & 17'h1FFFF;
			skc_pkg::CFG_LIMITER: lim_on = value[0];
			default: ;
		endcase
	endtask

	// Valid stays high into the next pair when there is no gap; drain drops it.
	task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			sample.valid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.left_in <= l;
		sample.right_in <= r;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		predict_pair(l, r);
		n_pairs++;
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (130)
			@(posedge clk);
	endtask

	// Random sample biased toward loud, quiet and extreme values.
	function automatic logic signed [23:0] rand_sample();
		int sel;
		logic signed [23:0] v;
		sel = $urandom_range(0, 9);
		case (sel)
			0: v = 24'sh800000;
			1: v = 24'sh7FFFFF;
			2: v = 24'(int'($urandom_range(0, 255)) - 128);
			3: v = $signed(24'($urandom)) >>> $urandom_range(0, 20);
			default: v = 24'($urandom);
		endcase
		return v;
	endfunction

	task automatic random_block(int count);
		for (int i = 0; i < count; i++)
			send_pair(rand_sample(), rand_sample(), 1'b1);
	endtask

	// Result acceptance with a random stall before every beat.
	initial begin
		int stall;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 13);
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall)
					@(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid)
				@(posedge clk);
			sb.check(result.left_out, result.right_out, result.reduction_db);
		end
	end

	initial begin
		#20ms;
		$display("Timeout");
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic signed [23:0] edge_vals[8];
		sb = new();
		n_pairs = 0;
		thr_db = -4608;
		slope = -49152;
		knee = 1536;
		atk = 65399;
		rel = 65522;
		wgain = 142680;
		mix = 65536;
		lim_on = 1'b1;
		smooth_red = 0;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.left_in = '0;
		sample.right_in = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at reset settings: zeros, extremes, floor level and a level above the knee.
		edge_vals = '{24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'sh000001, 24'shFFFFFF,
			24'sh400000, 24'sh0000A8, 24'sh1D5000};
		foreach (edge_vals[i])
			send_pair(edge_vals[i], edge_vals[7 - i], 1'b0);
		send_pair(24'sh800000, 24'sh800000, 1'b0);
		send_pair(24'sh000000, 24'sh000000, 1'b1);
		// Hard knee, fast coefficients, over-range mix and limiter off.
		drain();
		write_reg(skc_pkg::CFG_KNEE, 0);
		write_reg(skc_pkg::CFG_ATTACK, 0);
		write_reg(skc_pkg::CFG_RELEASE, 0);
		write_reg(skc_pkg::CFG_MIX, 131071);
		write_reg(skc_pkg::CFG_LIMITER, 0);
		write_reg(skc_pkg::CFG_WET_GAIN, 16777215);
		foreach (edge_vals[i])
			send_pair(edge_vals[i], -edge_vals[i], 1'b1);
		drain();
		write_reg(skc_pkg::CFG_THRESHOLD, -24576);
		write_reg(skc_pkg::CFG_SLOPE, -65536);
		write_reg(skc_pkg::CFG_KNEE, 6144);
		write_reg(skc_pkg::CFG_MIX, 0);
		write_reg(skc_pkg::CFG_ATTACK, 65535);
		write_reg(skc_pkg::CFG_RELEASE, 65535);
		send_pair(24'sh7FFFFF, 0, 1'b0);
		send_pair(24'sh800000, 24'sh7FFFFF, 1'b0);

		// Random phases across several settings.
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(skc_pkg::CFG_THRESHOLD, -4608);
					write_reg(skc_pkg::CFG_SLOPE, -49152);
					write_reg(skc_pkg::CFG_KNEE, 1536);
					write_reg(skc_pkg::CFG_ATTACK, 65399);
					write_reg(skc_pkg::CFG_RELEASE, 65522);
					write_reg(skc_pkg::CFG_WET_GAIN, 142680);
					write_reg(skc_pkg::CFG_MIX, 65536);
					write_reg(skc_pkg::CFG_LIMITER, 1);
				end
				1: begin
					write_reg(skc_pkg::CFG_THRESHOLD, 8192);
					write_reg(skc_pkg::CFG_SLOPE, 0);
					write_reg(skc_pkg::CFG_WET_GAIN, 0);
				end
				2: begin
					write_reg(skc_pkg::CFG_THRESHOLD, -24576);
					write_reg(skc_pkg::CFG_SLOPE, -65536);
					write_reg(skc_pkg::CFG_KNEE, 0);
					write_reg(skc_pkg::CFG_ATTACK, 0);
					write_reg(skc_pkg::CFG_RELEASE, 65535);
					write_reg(skc_pkg::CFG_WET_GAIN, 16777215);
					write_reg(skc_pkg::CFG_LIMITER, 0);
				end
				default: begin
					write_reg(skc_pkg::CFG_THRESHOLD, $urandom_range(0, 32768) - 24576);
					write_reg(skc_pkg::CFG_SLOPE, -longint'($urandom_range(0, 65536)));
					write_reg(skc_pkg::CFG_KNEE, $urandom_range(0, 6144));
					write_reg(skc_pkg::CFG_ATTACK, $urandom_range(0, 65535));
					write_reg(skc_pkg::CFG_RELEASE, $urandom_range(0, 65535));
					write_reg(skc_pkg::CFG_WET_GAIN, $urandom_range(0, 16777215));
					write_reg(skc_pkg::CFG_MIX, $urandom_range(0, 70000));
					write_reg(skc_pkg::CFG_LIMITER, $urandom_range(0, 1));
				end
			endcase
			random_block(200);
		end
		drain();

		$display("Sent %0d stereo pairs over directed edges and nine register settings.",
			n_pairs);
		$display("Checked %0d results, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

`default_nettype wire
